FILE: sv/colormap_interpolating_lookup_macros.svh
// Assertion macros shared by the checker of the colormap interpolating lookup.
`ifndef COLORMAP_INTERPOLATING_LOOKUP_MACROS_SVH
`define COLORMAP_INTERPOLATING_LOOKUP_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define CIL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cil checker: same-cycle property failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define CIL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cil checker: next-cycle property failed");

`endif

FILE: sv/cil_pkg.sv
// Package with widths, register codes and stage types of the colormap lookup.
package cil_pkg;

    localparam int IDX_W    = 8;
    localparam int FRAC_W   = 16;
    localparam int GAIN_W   = 32;
    localparam int SAMPLE_W = 16;
    localparam int CH_W     = 8;
    localparam int RGB_W    = 3 * CH_W;
    localparam int PROD_W   = GAIN_W + SAMPLE_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int POS_W    = IDX_W + FRAC_W;
    localparam int PAL_DEPTH = 2 ** IDX_W;
    localparam int BPROD_W  = FRAC_W + 1 + CH_W + 1;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam logic [1:0] REG_GAIN   = 2'd0;
    localparam logic [1:0] REG_OFFSET = 2'd1;
    localparam logic [1:0] REG_LAST   = 2'd2;

    localparam logic CMD_WRITE    = 1'b0;
    localparam logic CMD_COLORIZE = 1'b1;

    typedef struct packed {
        logic                     cmd;
        logic signed [PROD_W-1:0] prod;
        logic [IDX_W-1:0]         idx;
        logic [RGB_W-1:0]         rgb;
    } t_s1;

    typedef struct packed {
        logic              cmd;
        logic [IDX_W-1:0]  q;
        logic [FRAC_W-1:0] t;
        logic              lt;
        logic [IDX_W-1:0]  idx;
        logic [RGB_W-1:0]  rgb;
    } t_s2;

    typedef struct packed {
        logic [FRAC_W-1:0] t;
        logic              lt;
        logic [RGB_W-1:0]  c0;
        logic [RGB_W-1:0]  c1;
    } t_s3;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain;
        logic signed [GAIN_W-1:0] offset;
        logic [IDX_W-1:0]         last;
    } t_cfg;

endpackage

FILE: sv/cil_regs.sv
// Configuration registers of the colormap lookup behind an APB-style port.
module cil_regs
    import cil_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_sel;

    assign w_sel  = paddr[ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain   <= GAIN_W'(65536);
            r_cfg.offset <= '0;
            r_cfg.last   <= IDX_W'(255);
        end else if (w_wr) begin
            case (w_sel)
                REG_GAIN:   r_cfg.gain   <= pwdata;
                REG_OFFSET: r_cfg.offset <= pwdata;
                REG_LAST:   r_cfg.last   <= pwdata[IDX_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        case (w_sel)
            REG_GAIN:   prdata = r_cfg.gain;
            REG_OFFSET: prdata = r_cfg.offset;
            REG_LAST:   prdata = {{(DATA_W-IDX_W){1'b0}}, r_cfg.last};
            default:    prdata = '0;
        endcase
    end

endmodule

FILE: sv/cil_scale.sv
// Scale stages: multiply by gain, then add offset and clamp to a palette position.
module cil_scale
    import cil_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cfg                       i_cfg,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_cmd,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic [IDX_W-1:0]           i_idx,
    input  logic [RGB_W-1:0]           i_rgb,
    output logic                       o_valid,
    input  logic                       i_ready,
    output t_s2                        o_data
);

    logic                    r_v1;
    logic                    r_v2;
    t_s1                     r_s1;
    t_s2                     r_s2;
    t_s2                     n_s2;
    logic                    w_rdy1;
    logic                    w_rdy2;
    logic signed [SUM_W-1:0] w_sum;
    logic signed [SUM_W-1:0] w_top;
    logic [POS_W-1:0]        w_pos;

    assign w_rdy2  = !r_v2 || i_ready;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;
    assign o_valid = r_v2;
    assign o_data  = r_s2;

    always_comb begin
        w_sum = SUM_W'(r_s1.prod) + SUM_W'(i_cfg.offset);
        w_top = $signed({{(SUM_W-POS_W){1'b0}}, i_cfg.last, {FRAC_W{1'b0}}});
        if (w_sum < 0) begin
            w_pos = '0;
        end else if (w_sum > w_top) begin
            w_pos = w_top[POS_W-1:0];
        end else begin
            w_pos = w_sum[POS_W-1:0];
        end
        n_s2.cmd = r_s1.cmd;
        n_s2.q   = w_pos[POS_W-1:FRAC_W];
        n_s2.t   = w_pos[FRAC_W-1:0];
        n_s2.lt  = w_pos[POS_W-1:FRAC_W] != i_cfg.last;
        n_s2.idx = r_s1.idx;
        n_s2.rgb = r_s1.rgb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_valid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_s1.cmd  <= i_cmd;
            r_s1.prod <= PROD_W'(i_cfg.gain) * PROD_W'(i_sample);
            r_s1.idx  <= i_idx;
            r_s1.rgb  <= i_rgb;
        end
        if (w_rdy2) begin
            r_s2 <= n_s2;
        end
    end

endmodule

FILE: sv/cil_palette.sv
// Palette memory stage: stores entry writes and reads the two neighboring entries.
module cil_palette
    import cil_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_s2  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_s3  o_data
);

    logic [RGB_W-1:0] r_mem [PAL_DEPTH];
    logic             r_v;
    t_s3              r_s3;
    logic             w_en;
    logic [IDX_W-1:0] w_q1;

    assign w_en    = !r_v || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_v;
    assign o_data  = r_s3;
    assign w_q1    = i_data.q + IDX_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_en) begin
            r_v <= i_valid && (i_data.cmd == CMD_COLORIZE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && i_valid && (i_data.cmd == CMD_WRITE)) begin
            r_mem[i_data.idx] <= i_data.rgb;
        end
        if (w_en) begin
            r_s3.t  <= i_data.t;
            r_s3.lt <= i_data.lt;
            r_s3.c0 <= r_mem[i_data.q];
            r_s3.c1 <= r_mem[w_q1];
        end
    end

endmodule

FILE: sv/cil_blend.sv
// Blend stages: per-channel fraction times difference, then floor and add.
module cil_blend
    import cil_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  t_s3             i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [CH_W-1:0] o_red,
    output logic [CH_W-1:0] o_green,
    output logic [CH_W-1:0] o_blue
);

    logic                      r_v4;
    logic                      r_v5;
    logic signed [BPROD_W-1:0] r_prod [3];
    logic [RGB_W-1:0]          r_c0;
    logic [CH_W-1:0]           r_out  [3];
    logic signed [BPROD_W-1:0] n_prod [3];
    logic [CH_W-1:0]           n_out  [3];
    logic                      w_rdy4;
    logic                      w_rdy5;

    assign w_rdy5  = !r_v5 || i_ready;
    assign w_rdy4  = !r_v4 || w_rdy5;
    assign o_ready = w_rdy4;
    assign o_valid = r_v5;
    assign o_red   = r_out[0];
    assign o_green = r_out[1];
    assign o_blue  = r_out[2];

    always_comb begin
        logic [CH_W-1:0]         c0;
        logic [CH_W-1:0]         c1;
        logic signed [CH_W:0]    diff;
        logic signed [FRAC_W:0]  tf;
        logic signed [CH_W+1:0]  sum;
        tf = $signed({1'b0, i_data.t});
        for (int ch = 0; ch < 3; ch++) begin
            c0 = i_data.c0[RGB_W-1-CH_W*ch -: CH_W];
            c1 = i_data.lt ? i_data.c1[RGB_W-1-CH_W*ch -: CH_W] : c0;
            diff = $signed({1'b0, c1}) - $signed({1'b0, c0});
            n_prod[ch] = BPROD_W'(tf) * BPROD_W'(diff);
        end
        for (int ch = 0; ch < 3; ch++) begin
            sum = $signed({2'b00, r_c0[RGB_W-1-CH_W*ch -: CH_W]})
                + r_prod[ch][BPROD_W-1:FRAC_W];
            n_out[ch] = sum[CH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_rdy4) begin
                r_v4 <= i_valid;
            end
            if (w_rdy5) begin
                r_v5 <= r_v4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4) begin
            r_prod <= n_prod;
            r_c0   <= i_data.c0;
        end
        if (w_rdy5) begin
            r_out <= n_out;
        end
    end

endmodule

FILE: sv/colormap_interpolating_lookup.sv
// Top level of the colormap interpolating lookup.
// Input channel: i_valid/o_ready with i_command, i_sample, i_entry_index and
// the three entry color fields. A write transaction stores one palette entry
// and gives no result; a colorize transaction gives one RGB pixel.
// Output channel: o_valid/i_ready with o_red, o_green and o_blue.
// The pipeline has five register stages: gain multiply, offset add and clamp,
// palette read of two neighboring entries, blend multiply, and the final add
// that forms the output register. One transaction is accepted every cycle
// unless a receiver stall has filled the stages. Palette writes take effect
// in the memory stage, so they stay in order with colorize transactions. Every
// stage has its own valid bit and ready term, so when the receiver stalls the
// empty stages still fill and nothing is lost. Reset clears all valid bits
// and sets gain to 1.0, offset to 0 and last_index to 255; the palette has no
// reset and must be written before use. Configuration must be written through
// the APB-style port while the block is idle; the block does not enforce it.
module colormap_interpolating_lookup
    import cil_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ADDR_W-1:0]          paddr,
    input  logic [DATA_W-1:0]          pwdata,
    output logic [DATA_W-1:0]          prdata,
    output logic                       pready,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic                       i_command,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic [IDX_W-1:0]           i_entry_index,
    input  logic [CH_W-1:0]            i_entry_red,
    input  logic [CH_W-1:0]            i_entry_green,
    input  logic [CH_W-1:0]            i_entry_blue,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [CH_W-1:0]            o_red,
    output logic [CH_W-1:0]            o_green,
    output logic [CH_W-1:0]            o_blue
);

    t_cfg w_cfg;
    logic w_v2;
    logic w_r2;
    t_s2  w_s2;
    logic w_v3;
    logic w_r3;
    t_s3  w_s3;

    cil_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    cil_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_cmd    (i_command),
        .i_sample (i_sample),
        .i_idx    (i_entry_index),
        .i_rgb    ({i_entry_red, i_entry_green, i_entry_blue}),
        .o_valid  (w_v2),
        .i_ready  (w_r2),
        .o_data   (w_s2)
    );

    cil_palette u_palette (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v2),
        .o_ready (w_r2),
        .i_data  (w_s2),
        .o_valid (w_v3),
        .i_ready (w_r3),
        .o_data  (w_s3)
    );

    cil_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v3),
        .o_ready (w_r3),
        .i_data  (w_s3),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue)
    );

endmodule

FILE: sv/cil_checker.sv
// Port-level checker for the colormap interpolating lookup and its bind.
`include "colormap_interpolating_lookup_macros.svh"

module cil_checker
    import cil_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [ADDR_W-1:0] paddr,
    input logic [DATA_W-1:0] pwdata,
    input logic [DATA_W-1:0] prdata,
    input logic              pready,
    input logic              o_valid,
    input logic              i_ready,
    input logic [CH_W-1:0]   o_red,
    input logic [CH_W-1:0]   o_green,
    input logic [CH_W-1:0]   o_blue
);

    logic             w_stall;
    logic [RGB_W-1:0] w_pixel;
    logic             w_gain_wr;
    logic             w_gain_rd;
    logic             w_last_wr;
    logic             w_last_rd;

    assign w_stall   = o_valid && !i_ready;
    assign w_pixel   = {o_red, o_green, o_blue};
    assign w_gain_wr = psel && penable && pwrite && paddr[3:2] == REG_GAIN;
    assign w_gain_rd = psel && !pwrite && paddr[3:2] == REG_GAIN;
    assign w_last_wr = psel && penable && pwrite && paddr[3:2] == REG_LAST;
    assign w_last_rd = psel && !pwrite && paddr[3:2] == REG_LAST;

    `CIL_ASSERT_NOW(a_pready_high, 1'b1, pready)
    `CIL_ASSERT_NEXT(a_out_hold, w_stall, o_valid && $stable(w_pixel))
    `CIL_ASSERT_NOW(a_gain_readback, w_gain_rd && $past(w_gain_wr), prdata == $past(pwdata))
    `CIL_ASSERT_NOW(a_last_readback, w_last_rd && $past(w_last_wr), prdata == {24'd0, $past(pwdata[7:0])})

endmodule

bind colormap_interpolating_lookup cil_checker u_cil_checker (.*);
